// ===== sv/zuc_pkg.sv =====
package zuc_pkg;

	// request kinds on s_tuser
	localparam logic [1:0] OP_WR_CELL = 2'd0;
	localparam logic [1:0] OP_WR_F    = 2'd1;
	localparam logic [1:0] OP_INIT    = 2'd2;
	localparam logic [1:0] OP_KEY     = 2'd3;

	// F register select for OP_WR_F
	localparam logic [3:0] FREG_R1 = 4'd0;
	localparam logic [3:0] FREG_R2 = 4'd1;

	localparam int          CELL_W     = 31;
	localparam int          STEP_W     = 3;
	localparam logic [2:0]  STEP_FIRST = 3'd0;
	localparam logic [2:0]  STEP_LAST  = 3'd5;
	localparam logic [30:0] ZP         = 31'h7FFF_FFFF;
	localparam logic [5:0]  INIT_ROUNDS_RST = 6'd32;

	typedef struct packed {
		logic        cell_wr;
		logic        f_wr;
		logic [3:0]  wr_idx;
		logic [31:0] wr_data;
		logic [2:0]  step;
		logic        advance;   // last step of a round: shift LFSR, update F
	} zuc_ctrl_t;

	localparam logic [7:0] SBOX0 [256] = '{
	8'h3E,8'h72,8'h5B,8'h47,8'hCA,8'hE0,8'h00,8'h33,8'h04,8'hD1,8'h54,8'h98,8'h09,8'hB9,8'h6D,8'hCB,
	8'h7B,8'h1B,8'hF9,8'h32,8'hAF,8'h9D,8'h6A,8'hA5,8'hB8,8'h2D,8'hFC,8'h1D,8'h08,8'h53,8'h03,8'h90,
	8'h4D,8'h4E,8'h84,8'h99,8'hE4,8'hCE,8'hD9,8'h91,8'hDD,8'hB6,8'h85,8'h48,8'h8B,8'h29,8'h6E,8'hAC,
	8'hCD,8'hC1,8'hF8,8'h1E,8'h73,8'h43,8'h69,8'hC6,8'hB5,8'hBD,8'hFD,8'h39,8'h63,8'h20,8'hD4,8'h38,
	8'h76,8'h7D,8'hB2,8'hA7,8'hCF,8'hED,8'h57,8'hC5,8'hF3,8'h2C,8'hBB,8'h14,8'h21,8'h06,8'h55,8'h9B,
	8'hE3,8'hEF,8'h5E,8'h31,8'h4F,8'h7F,8'h5A,8'hA4,8'h0D,8'h82,8'h51,8'h49,8'h5F,8'hBA,8'h58,8'h1C,
	8'h4A,8'h16,8'hD5,8'h17,8'hA8,8'h92,8'h24,8'h1F,8'h8C,8'hFF,8'hD8,8'hAE,8'h2E,8'h01,8'hD3,8'hAD,
	8'h3B,8'h4B,8'hDA,8'h46,8'hEB,8'hC9,8'hDE,8'h9A,8'h8F,8'h87,8'hD7,8'h3A,8'h80,8'h6F,8'h2F,8'hC8,
	8'hB1,8'hB4,8'h37,8'hF7,8'h0A,8'h22,8'h13,8'h28,8'h7C,8'hCC,8'h3C,8'h89,8'hC7,8'hC3,8'h96,8'h56,
	8'h07,8'hBF,8'h7E,8'hF0,8'h0B,8'h2B,8'h97,8'h52,8'h35,8'h41,8'h79,8'h61,8'hA6,8'h4C,8'h10,8'hFE,
	8'hBC,8'h26,8'h95,8'h88,8'h8A,8'hB0,8'hA3,8'hFB,8'hC0,8'h18,8'h94,8'hF2,8'hE1,8'hE5,8'hE9,8'h5D,
	8'hD0,8'hDC,8'h11,8'h66,8'h64,8'h5C,8'hEC,8'h59,8'h42,8'h75,8'h12,8'hF5,8'h74,8'h9C,8'hAA,8'h23,
	8'h0E,8'h86,8'hAB,8'hBE,8'h2A,8'h02,8'hE7,8'h67,8'hE6,8'h44,8'hA2,8'h6C,8'hC2,8'h93,8'h9F,8'hF1,
	8'hF6,8'hFA,8'h36,8'hD2,8'h50,8'h68,8'h9E,8'h62,8'h71,8'h15,8'h3D,8'hD6,8'h40,8'hC4,8'hE2,8'h0F,
	8'h8E,8'h83,8'h77,8'h6B,8'h25,8'h05,8'h3F,8'h0C,8'h30,8'hEA,8'h70,8'hB7,8'hA1,8'hE8,8'hA9,8'h65,
	8'h8D,8'h27,8'h1A,8'hDB,8'h81,8'hB3,8'hA0,8'hF4,8'h45,8'h7A,8'h19,8'hDF,8'hEE,8'h78,8'h34,8'h60
	};

	localparam logic [7:0] SBOX1 [256] = '{
	8'h55,8'hC2,8'h63,8'h71,8'h3B,8'hC8,8'h47,8'h86,8'h9F,8'h3C,8'hDA,8'h5B,8'h29,8'hAA,8'hFD,8'h77,
	8'h8C,8'hC5,8'h94,8'h0C,8'hA6,8'h1A,8'h13,8'h00,8'hE3,8'hA8,8'h16,8'h72,8'h40,8'hF9,8'hF8,8'h42,
	8'h44,8'h26,8'h68,8'h96,8'h81,8'hD9,8'h45,8'h3E,8'h10,8'h76,8'hC6,8'hA7,8'h8B,8'h39,8'h43,8'hE1,
	8'h3A,8'hB5,8'h56,8'h2A,8'hC0,8'h6D,8'hB3,8'h05,8'h22,8'h66,8'hBF,8'hDC,8'h0B,8'hFA,8'h62,8'h48,
	8'hDD,8'h20,8'h11,8'h06,8'h36,8'hC9,8'hC1,8'hCF,8'hF6,8'h27,8'h52,8'hBB,8'h69,8'hF5,8'hD4,8'h87,
	8'h7F,8'h84,8'h4C,8'hD2,8'h9C,8'h57,8'hA4,8'hBC,8'h4F,8'h9A,8'hDF,8'hFE,8'hD6,8'h8D,8'h7A,8'hEB,
	8'h2B,8'h53,8'hD8,8'h5C,8'hA1,8'h14,8'h17,8'hFB,8'h23,8'hD5,8'h7D,8'h30,8'h67,8'h73,8'h08,8'h09,
	8'hEE,8'hB7,8'h70,8'h3F,8'h61,8'hB2,8'h19,8'h8E,8'h4E,8'hE5,8'h4B,8'h93,8'h8F,8'h5D,8'hDB,8'hA9,
	8'hAD,8'hF1,8'hAE,8'h2E,8'hCB,8'h0D,8'hFC,8'hF4,8'h2D,8'h46,8'h6E,8'h1D,8'h97,8'hE8,8'hD1,8'hE9,
	8'h4D,8'h37,8'hA5,8'h75,8'h5E,8'h83,8'h9E,8'hAB,8'h82,8'h9D,8'hB9,8'h1C,8'hE0,8'hCD,8'h49,8'h89,
	8'h01,8'hB6,8'hBD,8'h58,8'h24,8'hA2,8'h5F,8'h38,8'h78,8'h99,8'h15,8'h90,8'h50,8'hB8,8'h95,8'hE4,
	8'hD0,8'h91,8'hC7,8'hCE,8'hED,8'h0F,8'hB4,8'h6F,8'hA0,8'hCC,8'hF0,8'h02,8'h4A,8'h79,8'hC3,8'hDE,
	8'hA3,8'hEF,8'hEA,8'h51,8'hE6,8'h6B,8'h18,8'hEC,8'h1B,8'h2C,8'h80,8'hF7,8'h74,8'hE7,8'hFF,8'h21,
	8'h5A,8'h6A,8'h54,8'h1E,8'h41,8'h31,8'h92,8'h35,8'hC4,8'h33,8'h07,8'h0A,8'hBA,8'h7E,8'h0E,8'h34,
	8'h88,8'hB1,8'h98,8'h7C,8'hF3,8'h3D,8'h60,8'h6C,8'h7B,8'hCA,8'hD3,8'h1F,8'h32,8'h65,8'h04,8'h28,
	8'h64,8'hBE,8'h85,8'h9B,8'h2F,8'h59,8'h8A,8'hD7,8'hB0,8'h25,8'hAC,8'hAF,8'h12,8'h03,8'hE2,8'hF2
	};

	function automatic logic [31:0] l1(input logic [31:0] a);
		return a ^ {a[29:0], a[31:30]} ^ {a[21:0], a[31:22]}
			^ {a[13:0], a[31:14]} ^ {a[7:0], a[31:8]};
	endfunction

	function automatic logic [31:0] l2(input logic [31:0] b);
		return b ^ {b[23:0], b[31:24]} ^ {b[17:0], b[31:18]}
			^ {b[9:0], b[31:10]} ^ {b[1:0], b[31:2]};
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] t);
		return {SBOX0[t[31:24]], SBOX1[t[23:16]], SBOX0[t[15:8]], SBOX1[t[7:0]]};
	endfunction

endpackage

// ===== sv/zuc_lfsr.sv =====
module zuc_lfsr (
	input  logic              clk,
	input  zuc_pkg::zuc_ctrl_t ctrl,
	input  logic [30:0]       u,
	output logic [31:0]       x0,
	output logic [31:0]       x1,
	output logic [31:0]       x2,
	output logic [31:0]       x3
);
	import zuc_pkg::*;

	logic [CELL_W-1:0] cells_q [16];
	logic [CELL_W-1:0] acc_q;
	logic [CELL_W-1:0] base;
	logic [CELL_W-1:0] term;
	logic [CELL_W:0]   tot;
	logic [CELL_W-1:0] res;
	logic [CELL_W-1:0] fb;

	// one feedback term per step, rotations over 31 bits
	always_comb begin
		unique case (ctrl.step)
			3'd0: term = cells_q[0];
			3'd1: term = {cells_q[0][22:0], cells_q[0][30:23]};
			3'd2: term = {cells_q[4][10:0], cells_q[4][30:11]};
			3'd3: term = {cells_q[10][9:0], cells_q[10][30:10]};
			3'd4: term = {cells_q[13][13:0], cells_q[13][30:14]};
			default: term = {cells_q[15][15:0], cells_q[15][30:16]};
		endcase
	end

	// shared adder mod 2^31-1: end-around carry
	assign base = (ctrl.step == STEP_FIRST) ? u : acc_q;
	assign tot  = {1'b0, base} + {1'b0, term};
	assign res  = tot[CELL_W-1:0] + {{(CELL_W-1){1'b0}}, tot[CELL_W]};
	assign fb   = (res == '0) ? ZP : res;

	always_ff @(posedge clk) begin
		acc_q <= res;
		if (ctrl.advance) begin
			for (int i = 0; i < 15; i++) begin
				cells_q[i] <= cells_q[i+1];
			end
			cells_q[15] <= fb;
		end else if (ctrl.cell_wr) begin
			cells_q[ctrl.wr_idx] <= ctrl.wr_data[CELL_W-1:0];
		end
	end

	// bit reorganization
	assign x0 = {cells_q[15][30:15], cells_q[14][15:0]};
	assign x1 = {cells_q[11][15:0], cells_q[9][30:15]};
	assign x2 = {cells_q[7][15:0], cells_q[5][30:15]};
	assign x3 = {cells_q[2][15:0], cells_q[0][30:15]};

endmodule

// ===== sv/zuc_nlf.sv =====
module zuc_nlf (
	input  logic              clk,
	input  zuc_pkg::zuc_ctrl_t ctrl,
	input  logic [31:0]       x0,
	input  logic [31:0]       x1,
	input  logic [31:0]       x2,
	input  logic [31:0]       x3,
	output logic [31:0]       w,
	output logic [31:0]       z
);
	import zuc_pkg::*;

	logic [31:0] r1_q;
	logic [31:0] r2_q;
	logic [31:0] w1;
	logic [31:0] w2;
	logic [31:0] ta;
	logic [31:0] tb;

	assign w  = (x0 ^ r1_q) + r2_q;
	assign z  = w ^ x3;
	assign w1 = r1_q + x1;
	assign w2 = r2_q ^ x2;
	assign ta = {w1[15:0], w2[31:16]};
	assign tb = {w2[15:0], w1[31:16]};

	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			r1_q <= sbox_word(l1(ta));
			r2_q <= sbox_word(l2(tb));
		end else if (ctrl.f_wr) begin
			if (ctrl.wr_idx == FREG_R1) begin
				r1_q <= ctrl.wr_data;
			end else if (ctrl.wr_idx == FREG_R2) begin
				r2_q <= ctrl.wr_data;
			end
		end
	end

endmodule

// ===== sv/zuc_keystream_core.sv =====
// ZUC keystream core. Load the sixteen 31-bit LFSR cells (s_tuser = 0, cell number in
// the index field) and R1/R2 (s_tuser = 1, index 0 or 1), then send an initialize request
// (s_tuser = 2) and one keystream request (s_tuser = 3) per 32-bit word wanted; only
// keystream requests produce output on m_tdata. The LFSR feedback sum runs through a
// single mod 2^31-1 adder, one term per cycle, so each round runs one step per term; an
// initialize request runs init_rounds rounds, a keystream request one round and then a
// load of the output register, after which the core takes the next request in idle. The
// output register may hold a word while the next request is accepted; a keystream
// request waits only for that register to drain. init_rounds (reset 32) is written on
// the cfg channel; the user must write it only while the core is idle (not enforced).
module zuc_keystream_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [3:0] index, [35:4] value, [39:36] zero
	input  logic [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] keystream_word
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);
	import zuc_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_OUT   = 2'd2;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic [5:0]        round_q;
	logic [5:0]        init_rounds_q;
	logic              mode_init_q;
	logic              m_tvalid_q;
	logic [31:0]       m_tdata_q;
	logic              s_acc;
	logic              last_step;
	logic              out_free;
	zuc_ctrl_t         ctrl;
	logic [30:0]       u;
	logic [31:0]       x0, x1, x2, x3;
	logic [31:0]       w;
	logic [31:0]       z;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign last_step = (state_q == ST_ROUND) && (step_q == STEP_LAST);
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		ctrl.cell_wr = s_acc && (s_tuser == OP_WR_CELL);
		ctrl.f_wr    = s_acc && (s_tuser == OP_WR_F);
		ctrl.wr_idx  = s_tdata[3:0];
		ctrl.wr_data = s_tdata[35:4];
		ctrl.step    = step_q;
		ctrl.advance = last_step;
	end

	// feedback input: W>>1 during init rounds, zero for keystream
	assign u = mode_init_q ? w[31:1] : '0;

	zuc_lfsr u_lfsr (
		.clk  (clk),
		.ctrl (ctrl),
		.u    (u),
		.x0   (x0),
		.x1   (x1),
		.x2   (x2),
		.x3   (x3)
	);

	zuc_nlf u_nlf (
		.clk  (clk),
		.ctrl (ctrl),
		.x0   (x0),
		.x1   (x1),
		.x2   (x2),
		.x3   (x3),
		.w    (w),
		.z    (z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_rounds_q <= INIT_ROUNDS_RST;
		end else if (cfg_valid && cfg_ready) begin
			init_rounds_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_FIRST;
			round_q     <= '0;
			mode_init_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					step_q <= STEP_FIRST;
					if (s_acc && s_tuser == OP_INIT) begin
						round_q     <= '0;
						mode_init_q <= 1'b1;
						if (init_rounds_q != '0) begin
							state_q <= ST_ROUND;
						end
					end else if (s_acc && s_tuser == OP_KEY) begin
						mode_init_q <= 1'b0;
						state_q     <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (last_step) begin
						step_q <= STEP_FIRST;
						if (mode_init_q) begin
							round_q <= round_q + 6'd1;
							if (round_q + 6'd1 == init_rounds_q) begin
								state_q <= ST_IDLE;
							end
						end else begin
							state_q <= ST_OUT;
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= z;
		end
	end

`ifndef SYNTHESIS
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_LAST)
		else $error("round step counter out of range");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_OUT)
		else $error("output word without a keystream request");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && mode_init_q) |-> round_q < init_rounds_q)
		else $error("init round count overran init_rounds");
`endif

endmodule

// ===== dv/zuc_keystream_core_tb.sv =====
module zuc_keystream_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import zuc_pkg::*;

	localparam int          IDLE_WAIT  = 6 * 64 + 16;   // longest initialize plus margin
	localparam int          SINK_HOLD  = 300;
	localparam int          PHASE_ITEMS = 165;
	localparam logic [31:0] MOD31      = 32'h7FFF_FFFF;

	// Mirror of the core: LFSR cells, F registers, round setting and the words still owed.
	class zuc_mirror;
		logic [30:0] cells [16];
		logic [31:0] r1, r2;
		logic [5:0]  rounds;
		logic [31:0] x0, x1, x2, x3;
		logic [31:0] expected_words [$];
		int          mismatches;

		function new();
			foreach (cells[i]) cells[i] = '0;
			r1 = '0;
			r2 = '0;
			rounds = INIT_ROUNDS_RST;
			mismatches = 0;
		endfunction

		function logic [31:0] rotl32(input logic [31:0] v, input int k);
			logic [63:0] d;
			d = {v, v};
			d = d << k;
			return d[63:32];
		endfunction

		function logic [30:0] rotl31(input logic [30:0] v, input int k);
			logic [61:0] d;
			d = {v, v};
			d = d << k;
			return d[61:31];
		endfunction

		// odd byte lanes go through S0, even lanes through S1
		function logic [31:0] subst(input logic [31:0] t);
			logic [31:0] res;
			logic [7:0]  lane;
			for (int k = 0; k < 4; k++) begin
				lane = t[8*k +: 8];
				res[8*k +: 8] = k[0] ? SBOX0[lane] : SBOX1[lane];
			end
			return res;
		endfunction

		function void reorg();
			x0 = {cells[15][30:15], cells[14][15:0]};
			x1 = {cells[11][15:0], cells[9][30:15]};
			x2 = {cells[7][15:0], cells[5][30:15]};
			x3 = {cells[2][15:0], cells[0][30:15]};
		endfunction

		function void lfsr_push(input logic [30:0] u);
			longint unsigned acc;
			logic [30:0]     y;
			acc = {33'd0, u};
			acc = acc + {33'd0, cells[0]};
			acc = acc + {33'd0, rotl31(cells[0], 8)};
			acc = acc + {33'd0, rotl31(cells[4], 20)};
			acc = acc + {33'd0, rotl31(cells[10], 21)};
			acc = acc + {33'd0, rotl31(cells[13], 17)};
			acc = acc + {33'd0, rotl31(cells[15], 15)};
			acc = acc % {32'd0, MOD31};
			y = acc[30:0];
			if (y == '0)
				y = MOD31[30:0];
			for (int i = 0; i < 15; i++)
				cells[i] = cells[i + 1];
			cells[15] = y;
		endfunction

		function void f_step();
			logic [31:0] w1, w2, a, b;
			w1 = r1 + x1;
			w2 = r2 ^ x2;
			a = {w1[15:0], w2[31:16]};
			b = {w2[15:0], w1[31:16]};
			a = a ^ rotl32(a, 2) ^ rotl32(a, 10) ^ rotl32(a, 18) ^ rotl32(a, 24);
			b = b ^ rotl32(b, 8) ^ rotl32(b, 14) ^ rotl32(b, 22) ^ rotl32(b, 30);
			r1 = subst(a);
			r2 = subst(b);
		endfunction

		function void take_request(input logic [1:0] op, input logic [3:0] idx,
				input logic [31:0] val);
			logic [31:0] w;
			case (op)
				OP_WR_CELL: cells[idx] = val[30:0];
				OP_WR_F: begin
					if (idx == FREG_R1)
						r1 = val;
					else if (idx == FREG_R2)
						r2 = val;
				end
				OP_INIT: begin
					for (int n = 0; n < rounds; n++) begin
						reorg();
						w = (x0 ^ r1) + r2;
						lfsr_push(w[31:1]);
						f_step();
					end
				end
				default: begin
					reorg();
					f_step();
					lfsr_push('0);
					reorg();
					w = ((x0 ^ r1) + r2) ^ x3;
					expected_words = {expected_words, w};
				end
			endcase
		endfunction

		function void compare_word(input logic [31:0] got);
			logic [31:0] want;
			if (expected_words.size() == 0) begin
				$display("%0t: keystream word %h with no request pending (expected none)",
					$time, got);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				if (got !== want) begin
					$display("%0t: keystream word mismatch: expected %h, got %h",
						$time, want, got);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [5:0]  cfg_data;

	zuc_mirror mirror;
	bit        src_calm;
	bit        sink_calm;
	bit        sink_hold_req;

	zuc_keystream_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("zuc_keystream_core_tb: errors");
		$finish;
	end

	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// corner values show up often: zero, all ones, the modulus, top bit alone
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return MOD31;
			3: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_request(input logic [1:0] op, input logic [3:0] idx,
			input logic [31:0] val);
		int gap;
		gap = pick_gap(src_calm);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0000, val, idx};
		do @(posedge clk); while (!s_tready);
		mirror.take_request(op, idx, val);
	endtask

	task automatic write_rounds(input logic [5:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		mirror.rounds = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drop valid, collect every owed word, then let a possible initialize run out
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (mirror.pending() != 0)
			@(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic run_phase(input int budget);
		int          done;
		int          n_key;
		int          fill_sel;
		logic [1:0]  op;
		logic [3:0]  idx;
		logic [31:0] fill;
		done = 0;
		while (done < budget) begin
			src_calm = ($urandom_range(0, 4) == 0);
			sink_calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) != 0) begin
				// full key load, initialize, then a run of keystream requests
				fill_sel = $urandom_range(0, 9);
				fill = (fill_sel == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
				for (int i = 0; i < 16; i++)
					send_request(OP_WR_CELL, i[3:0], (fill_sel < 2) ? fill : pick_word());
				send_request(OP_WR_F, FREG_R1, pick_word());
				send_request(OP_WR_F, FREG_R2, pick_word());
				send_request(OP_INIT, 4'($urandom_range(0, 15)), $urandom);
				n_key = $urandom_range(1, 12);
				repeat (n_key) send_request(OP_KEY, 4'($urandom_range(0, 15)), $urandom);
				done += 19 + n_key;
			end else begin
				op = 2'($urandom_range(0, 3));
				idx = 4'($urandom_range(0, 15));
				send_request(op, idx, pick_word());
				if (!(op == OP_WR_F && idx > FREG_R2))
					done++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			mirror.compare_word(m_tdata);
	end

	initial begin : sink_side
		int   run;
		logic lvl;
		m_tready = 1'b0;
		run = 0;
		lvl = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (SINK_HOLD) @(negedge clk);
				m_tready <= 1'b1;
				run = 0;
			end else begin
				if (run == 0) begin
					if (sink_calm) begin
						lvl = 1'b1;
						run = 1;
					end else if ($urandom_range(0, 9) < 6) begin
						lvl = 1'b1;
						run = $urandom_range(1, 8);
					end else begin
						lvl = 1'b0;
						run = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
							: $urandom_range(1, 3);
					end
				end
				m_tready <= lvl;
				run--;
			end
		end
	end

	initial begin : stimulus
		logic [5:0] plan [8];
		mirror = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_WR_CELL;
		cfg_valid = 1'b0;
		cfg_data = '0;
		src_calm = 1'b0;
		sink_calm = 1'b0;
		sink_hold_req = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every cell at the modulus: the keystream feedback sum wraps to zero
		for (int i = 0; i < 16; i++)
			send_request(OP_WR_CELL, i[3:0], 32'hFFFF_FFFF);
		send_request(OP_WR_F, FREG_R1, 32'hFFFF_FFFF);
		send_request(OP_WR_F, FREG_R2, 32'h0000_0000);
		send_request(OP_WR_F, 4'd2, 32'hDEAD_BEEF);
		send_request(OP_WR_F, 4'd15, 32'h1234_5678);
		send_request(OP_KEY, 4'd0, 32'h0);
		send_request(OP_INIT, 4'd15, 32'hFFFF_FFFF);
		send_request(OP_KEY, 4'd15, 32'hFFFF_FFFF);
		settle();

		// zero rounds: initialize leaves the state alone
		write_rounds(6'd0);
		send_request(OP_INIT, 4'd0, 32'h0);
		send_request(OP_KEY, 4'd0, 32'h0);

		// back pressure: sink stalls while keystream requests keep coming
		settle();
		write_rounds(6'd32);
		src_calm = 1'b1;
		sink_hold_req = 1'b1;
		repeat (16) send_request(OP_KEY, 4'($urandom_range(0, 15)), $urandom);
		src_calm = 1'b0;

		plan = '{6'd63, 6'd1, 6'd0, 6'd0, 6'd32, 6'd2, 6'd0, 6'd63};
		plan[3] = 6'($urandom_range(0, 63));
		plan[6] = 6'($urandom_range(0, 63));
		foreach (plan[p]) begin
			settle();
			write_rounds(plan[p]);
			run_phase(PHASE_ITEMS);
		end
		settle();

		if (mirror.mismatches == 0)
			$display("zuc_keystream_core_tb: clean");
		else
			$display("zuc_keystream_core_tb: errors");
		$finish;
	end

endmodule
